/* rtl/pbsrb_pkg.sv */
// Types, codes and constants shared by the expansion card register block.
`timescale 1ns / 1ps
`default_nettype none

package pbsrb_pkg;

    // Item kinds on the input stream
    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_PRESS = 2'd2,
        FUNC_TICK  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        SEL_NONE = 2'd0,
        SEL_LOW  = 2'd1,
        SEL_HIGH = 2'd2
    } sel_act_t;

    typedef enum logic [1:0] {
        ACK_NONE  = 2'd0,
        ACK_PULSE = 2'd1,
        ACK_SET   = 2'd2,
        ACK_CLEAR = 2'd3
    } ack_act_t;

    typedef enum logic [1:0] {
        WIN_NONE = 2'd0,
        WIN_ROM  = 2'd1,
        WIN_OS   = 2'd2
    } win_act_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEVICE_EN = 2'd0;
    localparam logic [1:0] CFG_SCSI_EN   = 2'd1;
    localparam logic [1:0] CFG_ROM_LARGE = 2'd2;

    // Register page addresses (low byte)
    localparam logic [7:0] ADR_STATUS  = 8'h70;
    localparam logic [7:0] ADR_DATA    = 8'h71;
    localparam logic [7:0] ADR_PCR     = 8'h7c;
    localparam logic [7:0] ADR_RAMPAGE = 8'hbc;
    localparam logic [7:0] ADR_SWITCH  = 8'hbe;
    localparam logic [7:0] ADR_IRQ     = 8'hff;
    localparam logic [1:0] BANK_TOP    = 2'b11;

    // Handshake modes, taken from bits 3..1 of the control byte
    localparam logic [2:0] MODE_PULSE = 3'd4;
    localparam logic [2:0] MODE_LOW   = 3'd6;
    localparam logic [2:0] MODE_HIGH  = 3'd7;

    localparam logic [7:0] IRQ_STATUS = 8'h0a;
    localparam logic [7:0] SWITCH_RD  = 8'hff;

    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 40;

    typedef struct packed {
        func_t      func;
        logic [7:0] addr_low;
        logic [7:0] wdata;
        logic       debug_read;
        logic       scsi_req;
        logic       scsi_bsy;
        logic       scsi_sel;
        logic       scsi_cd;
        logic       scsi_io;
        logic [7:0] scsi_data_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       scsi_read_strobe;
        logic       scsi_data_write;
        sel_act_t   sel_action;
        ack_act_t   ack_action;
        win_act_t   window_action;
        logic [4:0] rom_block;
        logic       ram_page_swap;
        logic [7:0] ram_page_old;
        logic       irq_line;
        logic       cpu_irq_pulse;
        logic       irq_refresh;
    } result_t;

endpackage

`default_nettype wire

/* rtl/pbi_scsi_bank_register_block_core.sv */
// Register block of a parallel-bus expansion card: SCSI handshake, ROM bank and RAM page.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one item per cycle on the s_axis side: a bus read, a bus write, a button
// press or a frame tick, with the current SCSI line levels alongside. Every item gives exactly
// one result on the m_axis side: the item sits in an input register, one pass of decode logic
// works out the result and the new register state, and the result register holds it until
// taken. Throughput is one item per cycle; a stalled result only stops the input once the
// input register is also full. The result carries read data plus the actions that the host
// carries out: SEL and ACK line changes, ROM window switches (2K block number or OS ROM) and
// RAM page swaps (the old page number is given; the new one is the written byte).
// Configuration (card present, SCSI attached, 64K ROM) is written on the cfg port, which is
// always ready; the user must write it only while no item is in flight, as the block does
// not enforce this. All state and configuration clear on reset.
module pbi_scsi_bank_register_block_core
(
    input  wire                                  clk,
    input  wire                                  rst_n,
    // cfg_index: 0 device_enabled, 1 scsi_attached, 2 rom_large
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [1:0]                           cfg_index,
    input  wire                                  cfg_data,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata, low bit up: addr_low[7:0], wdata[15:8], scsi_req[16], scsi_bsy[17],
    // scsi_sel[18], scsi_cd[19], scsi_io[20], scsi_data_in[28:21], zero [31:29]
    input  wire  [pbsrb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser, low bit up: func[1:0], debug_read[2]
    input  wire  [pbsrb_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // tdata, low bit up: rdata[7:0], scsi_read_strobe[8], scsi_data_write[9],
    // sel_action[11:10], ack_action[13:12], window_action[15:14], rom_block[20:16],
    // ram_page_swap[21], ram_page_old[29:22], irq_line[30], cpu_irq_pulse[31],
    // irq_refresh[32], zero [39:33]
    output logic [pbsrb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import pbsrb_pkg::*;

    // Configuration
    logic       dev_en_reg;
    logic       scsi_en_reg;
    logic       rom_large_reg;

    // Card state
    logic [7:0] handshake_ctrl_reg, handshake_ctrl_next;
    logic [7:0] rom_bank_reg,       rom_bank_next;
    logic       rom_high_reg,       rom_high_next;
    logic [7:0] ram_page_reg,       ram_page_next;
    logic       button_down_reg,    button_down_next;
    logic       frame_counter_reg,  frame_counter_next;
    logic       button_irq_reg,     button_irq_next;

    // Pipeline
    logic       in_valid_reg;
    in_item_t   in_item_reg;
    in_item_t   in_item;
    logic       out_valid_reg;
    result_t    out_item_reg;
    result_t    res_next;
    logic       advance;
    logic [2:0] mode_cur;
    logic [2:0] mode_new;

    assign cfg_ready = 1'b1;

    // Unpack the incoming item
    always_comb
    begin
        in_item.func            = func_t'(s_axis_tuser[1:0]);
        in_item.debug_read      = s_axis_tuser[2];
        in_item.addr_low        = s_axis_tdata[7:0];
        in_item.wdata           = s_axis_tdata[15:8];
        in_item.scsi_req        = s_axis_tdata[16];
        in_item.scsi_bsy        = s_axis_tdata[17];
        in_item.scsi_sel        = s_axis_tdata[18];
        in_item.scsi_cd         = s_axis_tdata[19];
        in_item.scsi_io         = s_axis_tdata[20];
        in_item.scsi_data_in    = s_axis_tdata[28:21];
    end

    // Move the held item to the result register when that register is free or being taken
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign mode_cur = handshake_ctrl_reg[3:1];
    assign mode_new = in_item_reg.wdata[3:1];

    // Decode one item against the current state
    always_comb
    begin
        res_next            = '0;
        handshake_ctrl_next = handshake_ctrl_reg;
        rom_bank_next       = rom_bank_reg;
        rom_high_next       = rom_high_reg;
        ram_page_next       = ram_page_reg;
        button_down_next    = button_down_reg;
        frame_counter_next  = frame_counter_reg;
        button_irq_next     = button_irq_reg;

        unique case (in_item_reg.func)
            FUNC_READ:
            begin
                unique case (in_item_reg.addr_low)
                    ADR_STATUS:
                    begin
                        res_next.rdata = {~in_item_reg.scsi_req, ~in_item_reg.scsi_bsy, 3'b000,
                                          ~in_item_reg.scsi_sel, ~in_item_reg.scsi_cd,
                                          ~in_item_reg.scsi_io};
                    end
                    ADR_DATA:
                    begin
                        if (scsi_en_reg)
                        begin
                            res_next.rdata            = in_item_reg.scsi_data_in;
                            res_next.scsi_read_strobe = 1'b1;
                            // A debug read leaves the ACK line alone
                            if (!in_item_reg.debug_read && mode_cur == MODE_PULSE)
                            begin
                                res_next.ack_action = ACK_PULSE;
                            end
                        end
                    end
                    ADR_RAMPAGE: res_next.rdata = ram_page_reg;
                    ADR_SWITCH:  res_next.rdata = SWITCH_RD;
                    ADR_IRQ:     res_next.rdata = button_irq_reg ? IRQ_STATUS : 8'h00;
                    default:     res_next.rdata = 8'h00;
                endcase
            end
            FUNC_WRITE:
            begin
                unique case (in_item_reg.addr_low)
                    ADR_STATUS:
                    begin
                        if (scsi_en_reg)
                        begin
                            res_next.sel_action = in_item_reg.wdata[2] ? SEL_LOW : SEL_HIGH;
                        end
                    end
                    ADR_DATA:
                    begin
                        if (scsi_en_reg)
                        begin
                            res_next.scsi_data_write = 1'b1;
                            if (mode_cur == MODE_PULSE)
                            begin
                                res_next.ack_action = ACK_PULSE;
                            end
                        end
                    end
                    ADR_PCR:
                    begin
                        // The new mode decides the ACK level right away
                        handshake_ctrl_next = in_item_reg.wdata;
                        if (scsi_en_reg)
                        begin
                            if (mode_new == MODE_LOW)
                            begin
                                res_next.ack_action = ACK_SET;
                            end
                            else if (mode_new == MODE_HIGH)
                            begin
                                res_next.ack_action = ACK_CLEAR;
                            end
                        end
                    end
                    ADR_RAMPAGE:
                    begin
                        res_next.ram_page_swap = 1'b1;
                        res_next.ram_page_old  = ram_page_reg;
                        ram_page_next          = in_item_reg.wdata;
                    end
                    ADR_SWITCH:
                    begin
                        // High ROM half only exists on the 64K ROM
                        if (rom_large_reg && in_item_reg.wdata[2] != rom_high_reg)
                        begin
                            rom_high_next = in_item_reg.wdata[2];
                            if (rom_bank_reg != 8'h00 && rom_bank_reg[7:3] == 5'd0)
                            begin
                                res_next.window_action = WIN_ROM;
                                res_next.rom_block     = {in_item_reg.wdata[2], 1'b0,
                                                          rom_bank_reg[2:0]};
                            end
                        end
                    end
                    default:
                    begin
                        if (in_item_reg.addr_low[7:6] == BANK_TOP
                            && in_item_reg.wdata != rom_bank_reg)
                        begin
                            rom_bank_next = in_item_reg.wdata;
                            if (in_item_reg.wdata != 8'h00 && in_item_reg.wdata[7:4] == 4'd0)
                            begin
                                res_next.window_action = WIN_ROM;
                                // Small ROM folds banks 8..15 onto blocks 0..7
                                if (rom_large_reg)
                                begin
                                    res_next.rom_block = {rom_high_reg, in_item_reg.wdata[3:0]};
                                end
                                else
                                begin
                                    res_next.rom_block = {2'b00, in_item_reg.wdata[2:0]};
                                end
                            end
                            else
                            begin
                                res_next.window_action = WIN_OS;
                            end
                        end
                    end
                endcase
            end
            FUNC_PRESS:
            begin
                if (dev_en_reg && !button_down_reg)
                begin
                    res_next.cpu_irq_pulse = 1'b1;
                    button_irq_next        = 1'b1;
                    button_down_next       = 1'b1;
                end
            end
            FUNC_TICK:
            begin
                // Hold the button for one full frame, then release it
                if (button_down_reg)
                begin
                    if (!frame_counter_reg)
                    begin
                        frame_counter_next = 1'b1;
                    end
                    else
                    begin
                        button_irq_next      = 1'b0;
                        button_down_next     = 1'b0;
                        frame_counter_next   = 1'b0;
                        res_next.irq_refresh = 1'b1;
                    end
                end
            end
            default:
            begin
                res_next = '0;
            end
        endcase

        res_next.irq_line = button_irq_next;
    end

    // Control state, configuration and card state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_en_reg         <= 1'b0;
            scsi_en_reg        <= 1'b0;
            rom_large_reg      <= 1'b0;
            handshake_ctrl_reg <= 8'h00;
            rom_bank_reg       <= 8'h00;
            rom_high_reg       <= 1'b0;
            ram_page_reg       <= 8'h00;
            button_down_reg    <= 1'b0;
            frame_counter_reg  <= 1'b0;
            button_irq_reg     <= 1'b0;
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_DEVICE_EN: dev_en_reg    <= cfg_data;
                    CFG_SCSI_EN:   scsi_en_reg   <= cfg_data;
                    CFG_ROM_LARGE: rom_large_reg <= cfg_data;
                    default:       dev_en_reg    <= dev_en_reg;
                endcase
            end

            if (advance)
            begin
                handshake_ctrl_reg <= handshake_ctrl_next;
                rom_bank_reg       <= rom_bank_next;
                rom_high_reg       <= rom_high_next;
                ram_page_reg       <= ram_page_next;
                button_down_reg    <= button_down_next;
                frame_counter_reg  <= frame_counter_next;
                button_irq_reg     <= button_irq_next;
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_item_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0,
                            out_item_reg.irq_refresh,
                            out_item_reg.cpu_irq_pulse,
                            out_item_reg.irq_line,
                            out_item_reg.ram_page_old,
                            out_item_reg.ram_page_swap,
                            out_item_reg.rom_block,
                            out_item_reg.window_action,
                            out_item_reg.ack_action,
                            out_item_reg.sel_action,
                            out_item_reg.scsi_data_write,
                            out_item_reg.scsi_read_strobe,
                            out_item_reg.rdata};

`ifndef SYNTHESIS
    // A moved item always shows up on the output next cycle
    a_advance_shows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_axis_tvalid)
        else $error("advanced item missing from output");

    // The pending result reports the interrupt bit that the state now holds
    a_irq_matches: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_item_reg.irq_line == button_irq_reg))
        else $error("irq_line disagrees with button state");

    // A press that raised an interrupt left the button down with a fresh frame count
    a_press_state: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_item_reg.cpu_irq_pulse) |-> (button_down_reg && !frame_counter_reg))
        else $error("interrupt pulse without button held");

    // A ROM block mapping always follows a nonzero bank
    a_rom_bank: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_item_reg.window_action == WIN_ROM) |-> (rom_bank_reg != 8'h00))
        else $error("ROM block mapped with bank zero");
`endif

endmodule

`default_nettype wire

/* sim/pbi_scsi_bank_register_block_core_tb.sv */
// Self-checking stream testbench for the expansion card register block core.
`timescale 1ns / 1ps

module pbi_scsi_bank_register_block_core_tb;

    import pbsrb_pkg::*;

    // ---------------------------------------------------------------------
    // Clock, reset and block ports. Every input starts at a known value.
    // ---------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [1:0]              cfg_index = CFG_DEVICE_EN;
    logic                    cfg_data = 1'b0;

    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // tdata, low bit up: addr_low, wdata, scsi_req, scsi_bsy, scsi_sel, scsi_cd,
    // scsi_io, scsi_data_in, zero fill
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    // tuser, low bit up: func, debug_read
    logic [IN_TUSER_W-1:0]   s_axis_tuser = '0;

    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // tdata, low bit up: rdata, scsi_read_strobe, scsi_data_write, sel_action,
    // ack_action, window_action, rom_block, ram_page_swap, ram_page_old, irq_line,
    // cpu_irq_pulse, irq_refresh, zero fill
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;

    always #5 clk = ~clk;

    pbi_scsi_bank_register_block_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ---------------------------------------------------------------------
    // Card model state: configuration and the registers the block keeps.
    // ---------------------------------------------------------------------
    logic       card_present  = 1'b0;
    logic       scsi_attached = 1'b0;
    logic       rom_64k       = 1'b0;

    logic [7:0] pcr_byte      = '0;
    logic [7:0] rom_bank_byte = '0;
    logic       rom_hi_bit    = 1'b0;
    logic [7:0] ram_page_byte = '0;
    logic       button_held   = 1'b0;
    logic       frame_seen    = 1'b0;
    logic       button_irq_bit = 1'b0;

    in_item_t   bus_events_q[$];      // items still to be sent
    result_t    card_responses_q[$];  // predicted responses, oldest first
    in_item_t   presented_event;      // item currently on the input stream

    int         errors   = 0;
    int         tx_idle  = 0;
    int         tx_calm  = 0;
    int         rx_stall = 0;
    int         rx_calm  = 0;

    // ---------------------------------------------------------------------
    // Predict the response to one bus event and advance the card state.
    // ---------------------------------------------------------------------
    function automatic result_t card_response(input in_item_t ev);
        result_t    res;
        logic [2:0] mode;
        logic [7:0] b;
        res  = '0;
        b    = ev.wdata;
        mode = pcr_byte[3:1];
        case (ev.func)
            FUNC_READ:
            begin
                if (ev.addr_low == ADR_STATUS)
                begin
                    // Status lines read back inverted
                    res.rdata = {~ev.scsi_req, ~ev.scsi_bsy, 3'b000,
                                 ~ev.scsi_sel, ~ev.scsi_cd, ~ev.scsi_io};
                end
                else if (ev.addr_low == ADR_DATA)
                begin
                    if (scsi_attached)
                    begin
                        res.rdata = ev.scsi_data_in;
                        res.scsi_read_strobe = 1'b1;
                        // A debug read leaves the handshake alone
                        if (!ev.debug_read && mode == MODE_PULSE)
                            res.ack_action = ACK_PULSE;
                    end
                end
                else if (ev.addr_low == ADR_RAMPAGE)
                    res.rdata = ram_page_byte;
                else if (ev.addr_low == ADR_SWITCH)
                    res.rdata = SWITCH_RD;
                else if (ev.addr_low == ADR_IRQ)
                    res.rdata = button_irq_bit ? IRQ_STATUS : 8'h00;
            end
            FUNC_WRITE:
            begin
                if (ev.addr_low == ADR_STATUS)
                begin
                    if (scsi_attached)
                        res.sel_action = b[2] ? SEL_LOW : SEL_HIGH;
                end
                else if (ev.addr_low == ADR_DATA)
                begin
                    if (scsi_attached)
                    begin
                        res.scsi_data_write = 1'b1;
                        if (mode == MODE_PULSE)
                            res.ack_action = ACK_PULSE;
                    end
                end
                else if (ev.addr_low == ADR_PCR)
                begin
                    // The new control byte decides the ACK level
                    pcr_byte = b;
                    if (scsi_attached && b[3:1] == MODE_LOW)
                        res.ack_action = ACK_SET;
                    else if (scsi_attached && b[3:1] == MODE_HIGH)
                        res.ack_action = ACK_CLEAR;
                end
                else if (ev.addr_low == ADR_RAMPAGE)
                begin
                    res.ram_page_swap = 1'b1;
                    res.ram_page_old  = ram_page_byte;
                    ram_page_byte     = b;
                end
                else if (ev.addr_low == ADR_SWITCH)
                begin
                    // High ROM bit only exists on the 64K ROM
                    if (rom_64k && b[2] != rom_hi_bit)
                    begin
                        rom_hi_bit = b[2];
                        if (rom_bank_byte > 8'd0 && rom_bank_byte < 8'd8)
                        begin
                            res.window_action = WIN_ROM;
                            res.rom_block     = {rom_hi_bit, rom_bank_byte[3:0]};
                        end
                    end
                end
                else if (ev.addr_low[7:6] == BANK_TOP && rom_bank_byte != b)
                begin
                    res.window_action = WIN_OS;
                    if (!rom_64k && b >= 8'd8 && b <= 8'd15)
                    begin
                        res.window_action = WIN_ROM;
                        res.rom_block     = {2'b00, b[2:0]};
                    end
                    else if (!rom_64k && b > 8'd0 && b < 8'd8)
                    begin
                        res.window_action = WIN_ROM;
                        res.rom_block     = b[4:0];
                    end
                    else if (rom_64k && b > 8'd0 && b < 8'd16)
                    begin
                        res.window_action = WIN_ROM;
                        res.rom_block     = {rom_hi_bit, b[3:0]};
                    end
                    rom_bank_byte = b;
                end
            end
            FUNC_PRESS:
            begin
                if (card_present && !button_held)
                begin
                    res.cpu_irq_pulse = 1'b1;
                    button_irq_bit    = 1'b1;
                    button_held       = 1'b1;
                end
            end
            default:
            begin
                // Release the button on the second frame after the press
                if (button_held)
                begin
                    if (!frame_seen)
                        frame_seen = 1'b1;
                    else
                    begin
                        button_irq_bit  = 1'b0;
                        button_held     = 1'b0;
                        frame_seen      = 1'b0;
                        res.irq_refresh = 1'b1;
                    end
                end
            end
        endcase
        res.irq_line = button_irq_bit;
        return res;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a run without any
    function automatic int idle_len(inout int calm);
        int unsigned r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic in_item_t bus_op(input func_t f, input logic [7:0] a,
                                        input logic [7:0] d, input logic dbg,
                                        input logic [4:0] lines, input logic [7:0] din);
        in_item_t ev;
        ev.func            = f;
        ev.addr_low        = a;
        ev.wdata           = d;
        ev.debug_read      = dbg;
        {ev.scsi_req, ev.scsi_bsy, ev.scsi_sel, ev.scsi_cd, ev.scsi_io} = lines;
        ev.scsi_data_in    = din;
        return ev;
    endfunction

    // Random event weighted toward the decoded addresses and meaningful bytes
    function automatic in_item_t random_bus_event();
        in_item_t    ev;
        int unsigned r;
        logic [2:0]  mode;
        r = $urandom_range(0, 99);
        ev = bus_op(FUNC_TICK, 8'($urandom), 8'($urandom), 1'($urandom),
                    5'($urandom), 8'($urandom));
        if (r < 35)
            ev.func = FUNC_READ;
        else if (r < 75)
            ev.func = FUNC_WRITE;
        else if (r < 85)
            ev.func = FUNC_PRESS;
        case ($urandom_range(0, 11))
            0: ev.addr_low = ADR_STATUS;
            1: ev.addr_low = ADR_DATA;
            2: ev.addr_low = ADR_PCR;
            3: ev.addr_low = ADR_RAMPAGE;
            4: ev.addr_low = ADR_SWITCH;
            5: ev.addr_low = ADR_IRQ;
            6, 7, 8: ev.addr_low = {BANK_TOP, 6'($urandom)};
            default: ;
        endcase
        case ($urandom_range(0, 2))
            0: mode = MODE_PULSE;
            1: mode = MODE_LOW;
            default: mode = MODE_HIGH;
        endcase
        case ($urandom_range(0, 3))
            0: ev.wdata = 8'($urandom_range(0, 16));
            1: ev.wdata = {4'($urandom), mode, 1'($urandom)};
            default: ;
        endcase
        return ev;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // ---------------------------------------------------------------------
    // Driver: present queued items, predict each one as it is accepted.
    // ---------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                card_responses_q.push_back(card_response(presented_event));
            // Hold the item until taken; otherwise idle or advance to the next
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tx_idle > 0)
                begin
                    tx_idle--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (bus_events_q.size() != 0)
                begin
                    presented_event = bus_events_q.pop_front();
                    s_axis_tdata <= {3'b000, presented_event.scsi_data_in,
                                     presented_event.scsi_io, presented_event.scsi_cd,
                                     presented_event.scsi_sel, presented_event.scsi_bsy,
                                     presented_event.scsi_req, presented_event.wdata,
                                     presented_event.addr_low};
                    s_axis_tuser <= {presented_event.debug_read,
                                     presented_event.func};
                    s_axis_tvalid <= 1'b1;
                    tx_idle = idle_len(tx_calm);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result side back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (rx_stall > 0)
        begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 2) == 0)
                rx_stall = idle_len(rx_calm);
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: check every accepted result against the oldest prediction.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (card_responses_q.size() == 0)
            begin
                $error("result 0x%0h arrived with no item outstanding", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = card_responses_q.pop_front();
                compare_field("rdata",            want.rdata,            m_axis_tdata[7:0]);
                compare_field("scsi_read_strobe", want.scsi_read_strobe, m_axis_tdata[8]);
                compare_field("scsi_data_write",  want.scsi_data_write,  m_axis_tdata[9]);
                compare_field("sel_action",       want.sel_action,       m_axis_tdata[11:10]);
                compare_field("ack_action",       want.ack_action,       m_axis_tdata[13:12]);
                compare_field("window_action",    want.window_action,    m_axis_tdata[15:14]);
                compare_field("rom_block",        want.rom_block,        m_axis_tdata[20:16]);
                compare_field("ram_page_swap",    want.ram_page_swap,    m_axis_tdata[21]);
                compare_field("ram_page_old",     want.ram_page_old,     m_axis_tdata[29:22]);
                compare_field("irq_line",         want.irq_line,         m_axis_tdata[30]);
                compare_field("cpu_irq_pulse",    want.cpu_irq_pulse,    m_axis_tdata[31]);
                compare_field("irq_refresh",      want.irq_refresh,      m_axis_tdata[32]);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer: configuration phases, directed events, random events.
    // ---------------------------------------------------------------------
    task automatic write_cfg(input logic [1:0] idx, input logic val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DEVICE_EN: card_present  = val;
            CFG_SCSI_EN:   scsi_attached = val;
            default:       rom_64k       = val;
        endcase
    endtask

    task automatic set_card(input logic present, input logic scsi, input logic big);
        write_cfg(CFG_DEVICE_EN, present);
        write_cfg(CFG_SCSI_EN, scsi);
        write_cfg(CFG_ROM_LARGE, big);
    endtask

    // Wait until every item is sent and every response has come back
    task automatic settle();
        while (bus_events_q.size() != 0 || s_axis_tvalid || card_responses_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_events(input int count);
        repeat (count) bus_events_q.push_back(random_bus_event());
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Everything off: no SCSI, no button, 16K ROM
        set_card(1'b0, 1'b0, 1'b0);
        random_events(150);
        settle();

        // Card and SCSI on, 16K ROM: walk through every decoded address
        set_card(1'b1, 1'b1, 1'b0);
        bus_events_q.push_back(bus_op(FUNC_READ,  ADR_STATUS,  8'h00, 1'b0, 5'b00000, 8'h00));
        bus_events_q.push_back(bus_op(FUNC_READ,  ADR_STATUS,  8'hff, 1'b1, 5'b11111, 8'hff));
        bus_events_q.push_back(bus_op(FUNC_WRITE, ADR_PCR,     8'h08, 1'b0, 5'b00000, 8'h00));
        // Data read pulses ACK, a debug read must not
        bus_events_q.push_back(bus_op(FUNC_READ,  ADR_DATA,    8'h00, 1'b0, 5'b10101, 8'hff));
        bus_events_q.push_back(bus_op(FUNC_READ,  ADR_DATA,    8'h00, 1'b1, 5'b01010, 8'h00));
        bus_events_q.push_back(bus_op(FUNC_WRITE, ADR_DATA,    8'h5a, 1'b0, 5'b00000, 8'h00));
        bus_events_q.push_back(bus_op(FUNC_WRITE, ADR_PCR,     8'h0c, 1'b0, 5'b00000, 8'h00));
        bus_events_q.push_back(bus_op(FUNC_WRITE, ADR_PCR,     8'hff, 1'b0, 5'b00000, 8'h00));
        bus_events_q.push_back(bus_op(FUNC_WRITE, ADR_STATUS,  8'h04, 1'b0, 5'b00000, 8'h00));
        bus_events_q.push_back(bus_op(FUNC_WRITE, ADR_STATUS,  8'hfb, 1'b0, 5'b00000, 8'h00));
        bus_events_q.push_back(bus_op(FUNC_WRITE, ADR_RAMPAGE, 8'hff, 1'b0, 5'b00000, 8'h00));
        bus_events_q.push_back(bus_op(FUNC_READ,  ADR_RAMPAGE, 8'h00, 1'b0, 5'b00000, 8'h00));
        bus_events_q.push_back(bus_op(FUNC_READ,  ADR_SWITCH,  8'h00, 1'b0, 5'b00000, 8'h00));
        // High ROM bit is ignored on the 16K ROM
        bus_events_q.push_back(bus_op(FUNC_WRITE, ADR_SWITCH,  8'h04, 1'b0, 5'b00000, 8'h00));
        // Bank select: new byte, same byte again, upper half, beyond range, zero
        bus_events_q.push_back(bus_op(FUNC_WRITE, 8'hc0,       8'h03, 1'b0, 5'b00000, 8'h00));
        bus_events_q.push_back(bus_op(FUNC_WRITE, 8'hc0,       8'h03, 1'b0, 5'b00000, 8'h00));
        bus_events_q.push_back(bus_op(FUNC_WRITE, ADR_IRQ,     8'h0f, 1'b0, 5'b00000, 8'h00));
        bus_events_q.push_back(bus_op(FUNC_WRITE, 8'he5,       8'h10, 1'b0, 5'b00000, 8'h00));
        bus_events_q.push_back(bus_op(FUNC_WRITE, 8'hc0,       8'h00, 1'b0, 5'b00000, 8'h00));
        // Button: press, repeated press while down, two frames to release
        bus_events_q.push_back(bus_op(FUNC_PRESS, 8'h00,       8'h00, 1'b0, 5'b00000, 8'h00));
        bus_events_q.push_back(bus_op(FUNC_PRESS, 8'h00,       8'h00, 1'b0, 5'b00000, 8'h00));
        bus_events_q.push_back(bus_op(FUNC_READ,  ADR_IRQ,     8'h00, 1'b0, 5'b00000, 8'h00));
        bus_events_q.push_back(bus_op(FUNC_TICK,  8'h00,       8'h00, 1'b0, 5'b00000, 8'h00));
        bus_events_q.push_back(bus_op(FUNC_TICK,  8'h00,       8'h00, 1'b0, 5'b00000, 8'h00));
        random_events(250);
        settle();

        // Everything on with the 64K ROM: the high bit remaps the bank
        set_card(1'b1, 1'b1, 1'b1);
        bus_events_q.push_back(bus_op(FUNC_WRITE, 8'hc0,       8'h05, 1'b0, 5'b00000, 8'h00));
        bus_events_q.push_back(bus_op(FUNC_WRITE, ADR_SWITCH,  8'h04, 1'b0, 5'b00000, 8'h00));
        bus_events_q.push_back(bus_op(FUNC_WRITE, 8'hc1,       8'h0f, 1'b0, 5'b00000, 8'h00));
        bus_events_q.push_back(bus_op(FUNC_WRITE, ADR_SWITCH,  8'h00, 1'b0, 5'b00000, 8'h00));
        random_events(300);
        settle();

        set_card(1'b0, 1'b1, 1'b1);
        random_events(150);
        settle();

        set_card(1'b1, 1'b0, 1'b1);
        random_events(150);
        settle();

        // Drop back to the 16K ROM with the high bit possibly still set
        set_card(1'b1, 1'b1, 1'b0);
        random_events(150);
        settle();

        set_card(1'b1, 1'b1, 1'b1);
        random_events(100);
        settle();

        repeat (8) @(posedge clk);
        if (card_responses_q.size() != 0)
        begin
            $error("%0d responses never arrived", card_responses_q.size());
            errors++;
        end
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog well beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
